FILE: design/ttf_pkg.sv
`default_nettype none

package ttf_pkg;

  // Depth of the triangle queue between the front and the back.
  localparam int QDEPTH = 2;

  // Multiply sequence: products for normal, binormal and tangent first, then
  // the cross product of tangent and binormal and the dot with the normal.
  localparam int MAC_A_LAST = 18;
  localparam int MAC_B_FIRST = 18;
  localparam int MAC_B_LAST = 27;
  localparam int DOT_MID = 25;
  localparam int DOT_END = 26;

  // Slot of the corner that completes a triangle.
  localparam logic [1:0] LAST_SLOT = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } corner_t;

  typedef struct packed {
    corner_t c2;
    corner_t c1;
    corner_t c0;
  } tri_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic [1:0]         corner;
    logic               last;
  } frame_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } norm_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } norm_res_t;

  typedef enum logic [2:0] {
    N_IDLE, N_FIT, N_SQ, N_SQRT, N_DINIT, N_DIV, N_DONE
  } norm_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_FIT, B_MAC_A, B_NSTART, B_NWAIT, B_MAC_B, B_OUT
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/ttf_front.sv
`default_nettype none

module ttf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            corner_valid,
  output logic            corner_ready,
  input  ttf_pkg::corner_t corner,
  output logic            push,
  output ttf_pkg::tri_t   tri_data,
  input  logic            full
);

  logic [1:0]       count;
  ttf_pkg::corner_t c0;
  ttf_pkg::corner_t c1;
  logic             accept;

  // The completing corner can only be taken when the queue has room.
  assign corner_ready = !((count == ttf_pkg::LAST_SLOT) && full);
  assign accept = corner_valid && corner_ready;
  assign push = accept && (count == ttf_pkg::LAST_SLOT);

  assign tri_data.c0 = c0;
  assign tri_data.c1 = c1;
  assign tri_data.c2 = corner;

  // Corner counter within the current triangle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= (count == ttf_pkg::LAST_SLOT) ? 2'd0 : count + 2'd1;
    end
  end

  // Hold the first two corners until the third one arrives.
  always_ff @(posedge clk) begin
    if (accept && (count == 2'd0)) begin
      c0 <= corner;
    end
    if (accept && (count == 2'd1)) begin
      c1 <= corner;
    end
  end

endmodule

`default_nettype wire

FILE: design/ttf_queue.sv
`default_nettype none

module ttf_queue #(
  parameter int DEPTH = ttf_pkg::QDEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ttf_pkg::tri_t wdata,
  output logic          full,
  output logic          valid,
  output ttf_pkg::tri_t rdata,
  input  logic          pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ttf_pkg::tri_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full = (cnt == CW'(DEPTH));
  assign valid = (cnt != '0);
  assign rdata = mem[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Triangle storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: design/ttf_norm.sv
`default_nettype none

module ttf_norm (
  input  logic               clk,
  input  logic               rst,
  input  ttf_pkg::norm_req_t req,
  output ttf_pkg::norm_res_t res
);

  ttf_pkg::norm_state_t state;
  ttf_pkg::norm_state_t state_next;

  logic [63:0] mag [3];
  logic [2:0]  neg;
  logic [63:0] mx;
  logic [59:0] sq;
  logic [63:0] acc;
  logic [63:0] root;
  logic [4:0]  cnt;
  logic [45:0] rem [3];
  logic [14:0] quo [3];

  logic [30:0] len;
  logic [45:0] half;
  logic [45:0] dsh;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic [29:0] sq_in;
  logic [63:0] in_mag [3];

  assign len = root[30:0];
  assign half = {16'd0, len[30:1]};
  assign dsh = {15'd0, len} << cnt[3:0];
  assign bitv = 64'd1 << {cnt, 1'b0};
  assign trial = root + bitv;

  assign in_mag[0] = req.x[63] ? 64'd0 - req.x : req.x;
  assign in_mag[1] = req.y[63] ? 64'd0 - req.y : req.y;
  assign in_mag[2] = req.z[63] ? 64'd0 - req.z : req.z;

  // Square operand for the current term of the sum.
  always_comb begin
    unique case (cnt[1:0])
      2'd1:    sq_in = mag[1][29:0];
      2'd2:    sq_in = mag[2][29:0];
      default: sq_in = mag[0][29:0];
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ttf_pkg::N_IDLE:  if (req.start) state_next = ttf_pkg::N_FIT;
      ttf_pkg::N_FIT:   if (mx[63:30] == '0) state_next = ttf_pkg::N_SQ;
      ttf_pkg::N_SQ:    if (cnt == 5'd3) state_next = ttf_pkg::N_SQRT;
      ttf_pkg::N_SQRT:  if (cnt == 5'd0) state_next = ttf_pkg::N_DINIT;
      ttf_pkg::N_DINIT: state_next = (len == '0) ? ttf_pkg::N_DONE : ttf_pkg::N_DIV;
      ttf_pkg::N_DIV:   if (cnt == 5'd0) state_next = ttf_pkg::N_DONE;
      ttf_pkg::N_DONE:  state_next = ttf_pkg::N_IDLE;
      default:          state_next = ttf_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttf_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs: rounded quotients with the sign put back.
  always_comb begin
    res.done = (state == ttf_pkg::N_DONE);
    res.x = neg[0] ? 16'd0 - {1'b0, quo[0]} : {1'b0, quo[0]};
    res.y = neg[1] ? 16'd0 - {1'b0, quo[1]} : {1'b0, quo[1]};
    res.z = neg[2] ? 16'd0 - {1'b0, quo[2]} : {1'b0, quo[2]};
  end

  // Datapath: shared shift, sum of squares, square root, then three dividers.
  always_ff @(posedge clk) begin
    unique case (state)
      ttf_pkg::N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          mag[i] <= in_mag[i];
        end
        neg <= {req.z[63], req.y[63], req.x[63]};
        if (in_mag[0] >= in_mag[1] && in_mag[0] >= in_mag[2]) begin
          mx <= in_mag[0];
        end else if (in_mag[1] >= in_mag[2]) begin
          mx <= in_mag[1];
        end else begin
          mx <= in_mag[2];
        end
        cnt <= '0;
      end
      ttf_pkg::N_FIT: begin
        // Four bits at a time while that cannot overshoot, then single bits.
        if (mx[63:34] != '0) begin
          mx <= mx >> 4;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 4;
          end
        end else if (mx[63:30] != '0) begin
          mx <= mx >> 1;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end
        cnt <= '0;
      end
      ttf_pkg::N_SQ: begin
        sq <= sq_in * sq_in;
        if (cnt == 5'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + {4'd0, sq};
        end
        if (cnt == 5'd3) begin
          cnt  <= 5'd31;
          root <= '0;
        end else begin
          cnt <= cnt + 5'd1;
        end
      end
      ttf_pkg::N_SQRT: begin
        if (acc >= trial) begin
          acc  <= acc - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        cnt <= cnt - 5'd1;
      end
      ttf_pkg::N_DINIT: begin
        for (int i = 0; i < 3; i++) begin
          rem[i] <= {2'd0, mag[i][29:0], 14'd0} + half;
          quo[i] <= '0;
        end
        cnt <= 5'd14;
      end
      ttf_pkg::N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem[i] >= dsh) begin
            rem[i] <= rem[i] - dsh;
            quo[i][cnt[3:0]] <= 1'b1;
          end
        end
        cnt <= cnt - 5'd1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ttf_back.sv
`default_nettype none

module ttf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             tri_valid,
  input  ttf_pkg::tri_t    tri_data,
  output logic             tri_pop,
  output logic             frame_valid,
  input  logic             frame_ready,
  output ttf_pkg::frame_t  frame
);

  ttf_pkg::back_state_t state;
  ttf_pkg::back_state_t state_next;

  logic [1:0]         k;
  logic [1:0]         vi;
  logic [4:0]         step;
  logic [4:0]         p;
  logic signed [32:0] d_e [6];
  logic signed [32:0] d_du [2];
  logic signed [32:0] d_dv [2];
  logic signed [31:0] e [6];
  logic signed [31:0] du [2];
  logic signed [31:0] dv [2];
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] res [12];
  logic signed [15:0] nn [3];
  logic signed [15:0] tu [3];
  logic signed [15:0] bu [3];
  logic               flip;

  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] acc_sum;
  ttf_pkg::corner_t   ca;
  ttf_pkg::corner_t   cb;
  ttf_pkg::corner_t   cc;
  logic               sh_e;
  logic               sh_u;
  logic               sh_v;
  logic               load;
  ttf_pkg::norm_req_t nreq;
  ttf_pkg::norm_res_t nres;

  function automatic logic signed [32:0] sx(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] d);
    return d[32] ? 33'd0 - d : d;
  endfunction

  function automatic logic over31(input logic signed [32:0] d);
    logic [32:0] m;
    m = mag33(d);
    return m[32] | m[31];
  endfunction

  // Shift the magnitude, truncating toward zero, then restore the sign.
  function automatic logic signed [31:0] fit_one(input logic signed [32:0] d,
                                                 input logic sh);
    logic [32:0] m;
    logic [31:0] r;
    m = mag33(d);
    m = sh ? (m >> 1) : m;
    r = m[31:0];
    return d[32] ? 32'd0 - r : r;
  endfunction

  function automatic logic signed [31:0] sx16(input logic signed [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  assign p = step - 5'd1;
  assign acc_sum = acc + prod;
  assign load = (state == ttf_pkg::B_OUT) && (!frame_valid || frame_ready);
  assign tri_pop = load && (k == ttf_pkg::LAST_SLOT);

  // Corner order for frame k: A=k, B=k+1, C=k+2.
  always_comb begin
    unique case (k)
      2'd1: begin
        ca = tri_data.c1; cb = tri_data.c2; cc = tri_data.c0;
      end
      2'd2: begin
        ca = tri_data.c2; cb = tri_data.c0; cc = tri_data.c1;
      end
      default: begin
        ca = tri_data.c0; cb = tri_data.c1; cc = tri_data.c2;
      end
    endcase
  end

  always_comb begin
    sh_e = over31(d_e[0]) | over31(d_e[1]) | over31(d_e[2]) |
           over31(d_e[3]) | over31(d_e[4]) | over31(d_e[5]);
    sh_u = over31(d_du[0]) | over31(d_du[1]);
    sh_v = over31(d_dv[0]) | over31(d_dv[1]);
  end

  // Operand pair for each step of the multiply sequence.
  always_comb begin
    unique case (step)
      5'd0:  begin op_a = e[4]; op_b = e[2]; end
      5'd1:  begin op_a = e[5]; op_b = e[1]; end
      5'd2:  begin op_a = e[5]; op_b = e[0]; end
      5'd3:  begin op_a = e[3]; op_b = e[2]; end
      5'd4:  begin op_a = e[3]; op_b = e[1]; end
      5'd5:  begin op_a = e[4]; op_b = e[0]; end
      5'd6:  begin op_a = e[0]; op_b = du[1]; end
      5'd7:  begin op_a = e[3]; op_b = du[0]; end
      5'd8:  begin op_a = e[1]; op_b = du[1]; end
      5'd9:  begin op_a = e[4]; op_b = du[0]; end
      5'd10: begin op_a = e[2]; op_b = du[1]; end
      5'd11: begin op_a = e[5]; op_b = du[0]; end
      5'd12: begin op_a = e[0]; op_b = dv[1]; end
      5'd13: begin op_a = e[3]; op_b = dv[0]; end
      5'd14: begin op_a = e[1]; op_b = dv[1]; end
      5'd15: begin op_a = e[4]; op_b = dv[0]; end
      5'd16: begin op_a = e[2]; op_b = dv[1]; end
      5'd17: begin op_a = e[5]; op_b = dv[0]; end
      5'd18: begin op_a = sx16(tu[1]); op_b = sx16(bu[2]); end
      5'd19: begin op_a = sx16(tu[2]); op_b = sx16(bu[1]); end
      5'd20: begin op_a = sx16(tu[2]); op_b = sx16(bu[0]); end
      5'd21: begin op_a = sx16(tu[0]); op_b = sx16(bu[2]); end
      5'd22: begin op_a = sx16(tu[0]); op_b = sx16(bu[1]); end
      5'd23: begin op_a = sx16(tu[1]); op_b = sx16(bu[0]); end
      5'd24: begin op_a = res[9][31:0]; op_b = sx16(nn[0]); end
      5'd25: begin op_a = res[10][31:0]; op_b = sx16(nn[1]); end
      5'd26: begin op_a = res[11][31:0]; op_b = sx16(nn[2]); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Vector handed to the normalizer: normal, then binormal, then tangent.
  always_comb begin
    nreq.start = (state == ttf_pkg::B_NSTART);
    unique case (vi)
      2'd1: begin nreq.x = res[3]; nreq.y = res[4]; nreq.z = res[5]; end
      2'd2: begin nreq.x = res[6]; nreq.y = res[7]; nreq.z = res[8]; end
      default: begin nreq.x = res[0]; nreq.y = res[1]; nreq.z = res[2]; end
    endcase
  end

  ttf_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .res (nres)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ttf_pkg::B_IDLE:   if (tri_valid) state_next = ttf_pkg::B_LOAD;
      ttf_pkg::B_LOAD:   state_next = ttf_pkg::B_FIT;
      ttf_pkg::B_FIT:    state_next = ttf_pkg::B_MAC_A;
      ttf_pkg::B_MAC_A:  begin
        if (step == 5'(ttf_pkg::MAC_A_LAST)) state_next = ttf_pkg::B_NSTART;
      end
      ttf_pkg::B_NSTART: state_next = ttf_pkg::B_NWAIT;
      ttf_pkg::B_NWAIT:  begin
        if (nres.done) begin
          state_next = (vi == 2'd2) ? ttf_pkg::B_MAC_B : ttf_pkg::B_NSTART;
        end
      end
      ttf_pkg::B_MAC_B:  begin
        if (step == 5'(ttf_pkg::MAC_B_LAST)) state_next = ttf_pkg::B_OUT;
      end
      ttf_pkg::B_OUT:    begin
        if (load) begin
          state_next = (k == ttf_pkg::LAST_SLOT) ? ttf_pkg::B_IDLE : ttf_pkg::B_LOAD;
        end
      end
      default:           state_next = ttf_pkg::B_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttf_pkg::B_IDLE;
      k     <= '0;
      vi    <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ttf_pkg::B_FIT:   step <= '0;
        ttf_pkg::B_MAC_A: begin
          step <= step + 5'd1;
          vi   <= '0;
        end
        ttf_pkg::B_NWAIT: begin
          if (nres.done) begin
            vi   <= vi + 2'd1;
            step <= 5'(ttf_pkg::MAC_B_FIRST);
          end
        end
        ttf_pkg::B_MAC_B: step <= step + 5'd1;
        ttf_pkg::B_OUT:   begin
          if (load) begin
            k <= (k == ttf_pkg::LAST_SLOT) ? 2'd0 : k + 2'd1;
          end
        end
        default:          step <= step;
      endcase
    end
  end

  // Edges, shared shifts and the multiply-accumulate sequence.
  always_ff @(posedge clk) begin
    if (state == ttf_pkg::B_LOAD) begin
      d_e[0] <= sx(ca.pos_x) - sx(cb.pos_x);
      d_e[1] <= sx(ca.pos_y) - sx(cb.pos_y);
      d_e[2] <= sx(ca.pos_z) - sx(cb.pos_z);
      d_e[3] <= sx(cc.pos_x) - sx(ca.pos_x);
      d_e[4] <= sx(cc.pos_y) - sx(ca.pos_y);
      d_e[5] <= sx(cc.pos_z) - sx(ca.pos_z);
      d_du[0] <= sx(ca.tex_u) - sx(cb.tex_u);
      d_du[1] <= sx(cc.tex_u) - sx(ca.tex_u);
      d_dv[0] <= sx(ca.tex_v) - sx(cb.tex_v);
      d_dv[1] <= sx(cc.tex_v) - sx(ca.tex_v);
    end
    if (state == ttf_pkg::B_FIT) begin
      for (int i = 0; i < 6; i++) begin
        e[i] <= fit_one(d_e[i], sh_e);
      end
      for (int i = 0; i < 2; i++) begin
        du[i] <= fit_one(d_du[i], sh_u);
        dv[i] <= fit_one(d_dv[i], sh_v);
      end
    end
    if (state == ttf_pkg::B_MAC_A || state == ttf_pkg::B_MAC_B) begin
      prod <= op_a * op_b;
      // Consume the product of the previous step.
      if ((state == ttf_pkg::B_MAC_A && step != 5'd0) ||
          (state == ttf_pkg::B_MAC_B && step != 5'(ttf_pkg::MAC_B_FIRST))) begin
        if (p == 5'(ttf_pkg::DOT_MID)) begin
          acc <= acc_sum;
        end else if (p == 5'(ttf_pkg::DOT_END)) begin
          flip <= acc_sum[63];
        end else if (!p[0]) begin
          acc <= prod;
        end else begin
          res[p[4:1]] <= acc - prod;
        end
      end
    end
    if (state == ttf_pkg::B_NWAIT && nres.done) begin
      unique case (vi)
        2'd1: begin tu[0] <= '0; bu[0] <= nres.x; bu[1] <= nres.y; bu[2] <= nres.z; end
        2'd2: begin tu[0] <= nres.x; tu[1] <= nres.y; tu[2] <= nres.z; end
        default: begin nn[0] <= nres.x; nn[1] <= nres.y; nn[2] <= nres.z; end
      endcase
    end
  end

  // Output register; the frame waits here while the back moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (load) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame.normal_x    <= nn[0];
      frame.normal_y    <= nn[1];
      frame.normal_z    <= nn[2];
      frame.tangent_x   <= flip ? 16'sd0 - tu[0] : tu[0];
      frame.tangent_y   <= flip ? 16'sd0 - tu[1] : tu[1];
      frame.tangent_z   <= flip ? 16'sd0 - tu[2] : tu[2];
      frame.bitangent_x <= flip ? 16'sd0 - bu[0] : bu[0];
      frame.bitangent_y <= flip ? 16'sd0 - bu[1] : bu[1];
      frame.bitangent_z <= flip ? 16'sd0 - bu[2] : bu[2];
      frame.corner      <= k;
      frame.last        <= (k == ttf_pkg::LAST_SLOT);
    end
  end

endmodule

`default_nettype wire

FILE: design/triangle_tangent_frame.sv
// The pace is set by the shared normalizer (32-step square root and 15-step
// dividers), used nine times per triangle, one vector at a time. A frame takes
// longer when the products need long shifts in the normalizer and less time
// for zero vectors, which skip the division. The front and the queue keep taking
// corners while the back works on a triangle, until the queue is full. Reset
// (rst, synchronous) drops a partial triangle, the queue and any frame.
`default_nettype none

module triangle_tangent_frame #(
  parameter int QDEPTH = ttf_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             corner_valid,
  output logic             corner_ready,
  input  ttf_pkg::corner_t corner,
  output logic             frame_valid,
  input  logic             frame_ready,
  output ttf_pkg::frame_t  frame
);

  logic          push;
  logic          full;
  logic          tri_valid;
  logic          tri_pop;
  ttf_pkg::tri_t push_data;
  ttf_pkg::tri_t tri_data;

  // Front: collect three corners into a triangle.
  ttf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .corner_valid (corner_valid),
    .corner_ready (corner_ready),
    .corner       (corner),
    .push         (push),
    .tri_data     (push_data),
    .full         (full)
  );

  // Queue of complete triangles.
  ttf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .valid (tri_valid),
    .rdata (tri_data),
    .pop   (tri_pop)
  );

  // Back: three frames per triangle.
  ttf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tri_valid   (tri_valid),
    .tri_data    (tri_data),
    .tri_pop     (tri_pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

endmodule

`default_nettype wire

FILE: design/ttf_checker.sv
`default_nettype none

module ttf_checker (
  input logic            clk,
  input logic            rst,
  input logic            frame_valid,
  input logic            frame_ready,
  input ttf_pkg::frame_t frame
);

  // A waiting frame transaction keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(frame))
    else $error("frame changed while stalled");

  // The last flag marks exactly the third corner.
  a_last: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame.last == (frame.corner == 2'd2)))
    else $error("last flag does not match corner");

  // Reset leaves no frame pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !frame_valid)
    else $error("frame valid after reset");

  // Normal x and z components never exceed one in Q2.14.
  a_unit: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> ($signed(frame.normal_x) <= 16'sd16384) &&
                    ($signed(frame.normal_x) >= -16'sd16384) &&
                    ($signed(frame.normal_z) <= 16'sd16384) &&
                    ($signed(frame.normal_z) >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
  .clk         (clk),
  .rst         (rst),
  .frame_valid (frame_valid),
  .frame_ready (frame_ready),
  .frame       (frame)
);

`default_nettype wire
